[rtl/rmt_pkg.sv]
// Shared types and defaults for the running median tracker.
// No dependencies; every other file in rtl/ imports this package.
package rmt_pkg;

	localparam int unsigned CAPACITY_DEF     = 256;
	localparam int unsigned SAMPLE_WIDTH_DEF = 32;

	// Per-cycle command broadcast to every cell of a chain
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_PUSH,
		OP_POP
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_BAL,
		ST_MED
	} state_t;

endpackage

[rtl/running_median_tracker.sv]
// Running median tracker: top level with the sequencer and the two chains.
// Depends on rmt_pkg and rmt_chain (which instantiates rmt_cell).
//
// Every request carries one signed sample; the block answers each with one
// result: the median of all samples held so far, the number held, and a
// drop flag. Samples live in two sorted cell chains: the lower half
// (largest value at its head) and the upper half (smallest value at its
// head), so the median is always read from the two heads. An accepted
// sample is first inserted into a chain, then the halves are rebalanced by
// moving a head across, and then the median is formed from the heads and
// loaded into the output register. A request that finds the store full
// skips insert and rebalance and goes straight to the median step. The
// median step waits for as long as the output register holds a result that
// out_ready has not yet taken. in_ready is high only between items; the
// output register lets a new request be accepted while the previous
// result still waits for out_ready. No clearing pass is needed after reset.
module running_median_tracker #(
	parameter int unsigned CAPACITY     = rmt_pkg::CAPACITY_DEF,
	parameter int unsigned SAMPLE_WIDTH = rmt_pkg::SAMPLE_WIDTH_DEF,
	localparam int unsigned CW          = $clog2(CAPACITY + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] median,
	output logic        [CW-1:0]           stored_count,
	output logic                           dropped
);
	import rmt_pkg::*;

	localparam int unsigned W = SAMPLE_WIDTH;
	// one spare cell per half holds the sample before rebalancing
	localparam int unsigned HALF_DEPTH = CAPACITY / 2 + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t              state_q, state_nxt;
	logic signed [W-1:0] sample_q;
	logic [CW-1:0]       count_q;
	logic                to_lo_q;
	logic                drop_q;

	logic signed [W-1:0] median_q;
	logic [CW-1:0]       stored_count_q;
	logic                dropped_q;
	logic                out_valid_q;

	logic signed [W-1:0] lo_head, hi_head;
	op_t                 lo_op, hi_op;
	logic                accept, full, to_lo, out_load;
	logic                move_up, move_dn;

	logic signed [W:0]   pair_sum, pair_adj;
	logic signed [W-1:0] median_nxt;

	// lower half: descending, head is its maximum
	rmt_chain #(
		.DEPTH   (HALF_DEPTH),
		.W       (W),
		.DESCEND (1'b1)
	) u_lo (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (lo_op),
		.ins_val  (sample_q),
		.push_val (hi_head),
		.head_val (lo_head)
	);

	// upper half: ascending, head is its minimum
	rmt_chain #(
		.DEPTH   (HALF_DEPTH),
		.W       (W),
		.DESCEND (1'b0)
	) u_hi (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (hi_op),
		.ins_val  (sample_q),
		.push_val (lo_head),
		.head_val (hi_head)
	);

	assign full  = (count_q == CAP_C);
	// empty store or sample no larger than the lower maximum: goes low
	assign to_lo = (count_q == '0) || (sample_q <= lo_head);

	// count_q already counts the new sample during rebalance
	assign move_up = to_lo_q && !count_q[0];
	assign move_dn = !to_lo_q && count_q[0];

	// even count: mean of the heads, truncated toward zero
	assign pair_sum   = {lo_head[W-1], lo_head} + {hi_head[W-1], hi_head};
	assign pair_adj   = pair_sum + {{W{1'b0}}, pair_sum[W]};
	assign median_nxt = count_q[0] ? lo_head : pair_adj[W:1];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = full ? ST_MED : ST_INS;
				end
			end
			ST_INS:  state_nxt = ST_BAL;
			ST_BAL:  state_nxt = ST_MED;
			ST_MED: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		lo_op    = OP_HOLD;
		hi_op    = OP_HOLD;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_INS: begin
				if (to_lo) begin
					lo_op = OP_INSERT;
				end else begin
					hi_op = OP_INSERT;
				end
			end
			ST_BAL: begin
				if (move_up) begin
					lo_op = OP_POP;
					hi_op = OP_PUSH;
				end else if (move_dn) begin
					hi_op = OP_POP;
					lo_op = OP_PUSH;
				end
			end
			ST_MED:  out_load = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				drop_q <= full;
			end
			if (state_q == ST_INS) begin
				count_q <= count_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (state_q == ST_INS) begin
			to_lo_q <= to_lo;
		end
		if (out_load) begin
			median_q       <= median_nxt;
			stored_count_q <= count_q;
			dropped_q      <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign median       = median_q;
	assign stored_count = stored_count_q;
	assign dropped      = dropped_q;

endmodule

[rtl/rmt_cell.sv]
// One storage cell of a sorted chain: a value, its valid flag, and the
// neighbour exchange for insert, push and pop. Depends on rmt_pkg.
module rmt_cell #(
	parameter int unsigned W       = rmt_pkg::SAMPLE_WIDTH_DEF,
	parameter bit          DESCEND = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmt_pkg::op_t         op,
	input  logic signed [W-1:0]  ins_val,
	input  logic signed [W-1:0]  prev_val,
	input  logic                 prev_ins,
	input  logic                 prev_valid,
	input  logic signed [W-1:0]  next_val,
	input  logic                 next_valid,
	output logic signed [W-1:0]  val,
	output logic                 ins,
	output logic                 valid
);
	import rmt_pkg::*;

	logic signed [W-1:0] val_q;
	logic                valid_q;
	logic                goes_before;

	// the new value belongs ahead of this cell's value
	assign goes_before = DESCEND ? (ins_val > val_q) : (ins_val < val_q);
	assign ins         = !valid_q || goes_before;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_INSERT: begin
				if (ins) begin
					val_q <= prev_ins ? prev_val : ins_val;
				end
			end
			OP_PUSH:  val_q <= prev_val;
			OP_POP:   val_q <= next_val;
			OP_HOLD:  val_q <= val_q;
			default:  val_q <= val_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_INSERT, OP_PUSH: valid_q <= valid_q | prev_valid;
				OP_POP:             valid_q <= next_valid;
				OP_HOLD:            valid_q <= valid_q;
				default:            valid_q <= valid_q;
			endcase
		end
	end

	assign val   = val_q;
	assign valid = valid_q;

endmodule

[rtl/rmt_chain.sv]
// Sorted chain of rmt_cell instances with the extreme value at the head.
// Depends on rmt_pkg and rmt_cell.
module rmt_chain #(
	parameter int unsigned DEPTH   = rmt_pkg::CAPACITY_DEF / 2 + 1,
	parameter int unsigned W       = rmt_pkg::SAMPLE_WIDTH_DEF,
	parameter bit          DESCEND = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmt_pkg::op_t        op,
	input  logic signed [W-1:0] ins_val,
	input  logic signed [W-1:0] push_val,
	output logic signed [W-1:0] head_val
);
	import rmt_pkg::*;

	logic signed [W-1:0] vals  [DEPTH];
	logic                inss  [DEPTH];
	logic                valids[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [W-1:0] p_val;
		logic                p_ins;
		logic                p_valid;
		logic signed [W-1:0] n_val;
		logic                n_valid;

		if (i == 0) begin : g_head
			// head takes the pushed value on a push and becomes valid on every insert or push
			assign p_val   = push_val;
			assign p_ins   = 1'b0;
			assign p_valid = 1'b1;
		end else begin : g_body
			assign p_val   = vals[i-1];
			assign p_ins   = inss[i-1];
			assign p_valid = valids[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_val   = vals[i];
			assign n_valid = 1'b0;
		end else begin : g_inner
			assign n_val   = vals[i+1];
			assign n_valid = valids[i+1];
		end

		rmt_cell #(
			.W       (W),
			.DESCEND (DESCEND)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.ins_val    (ins_val),
			.prev_val   (p_val),
			.prev_ins   (p_ins),
			.prev_valid (p_valid),
			.next_val   (n_val),
			.next_valid (n_valid),
			.val        (vals[i]),
			.ins        (inss[i]),
			.valid      (valids[i])
		);
	end

	assign head_val = vals[0];

endmodule

[rtl/rmt_checker.sv]
// Port-level checks for running_median_tracker, bound to the top level.
// Depends on rmt_pkg for parameter defaults.
module rmt_checker #(
	parameter int unsigned CAPACITY     = rmt_pkg::CAPACITY_DEF,
	parameter int unsigned SAMPLE_WIDTH = rmt_pkg::SAMPLE_WIDTH_DEF,
	localparam int unsigned CW          = $clog2(CAPACITY + 1)
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [SAMPLE_WIDTH-1:0] sample,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] median,
	input logic [CW-1:0]           stored_count,
	input logic                    dropped
);
	import rmt_pkg::*;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// one request in flight: no back-to-back acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted in consecutive cycles");

	// a waiting request holds its sample
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
		else $error("waiting request changed");

	// a drop only happens on a full store
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> stored_count == CAP_C)
		else $error("drop reported below capacity");

	// every result follows at least one stored sample and reports no more than CAPACITY
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stored_count != '0 && stored_count <= CAP_C)
		else $error("stored count out of range");

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median)
			&& $stable(stored_count) && $stable(dropped))
		else $error("stalled result changed");

endmodule

bind running_median_tracker rmt_checker #(
	.CAPACITY     (CAPACITY),
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.sample       (sample),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.median       (median),
	.stored_count (stored_count),
	.dropped      (dropped)
);

[tb/running_median_tracker_tb.sv]
// Self-checking testbench for running_median_tracker: predicts median, count and drop flag
// per request from its own sorted copy of the samples and checks every result in order.
// Depends on rmt_pkg and the running_median_tracker RTL; needs nothing else.
`timescale 1ns / 1ps

module running_median_tracker_tb;

	localparam int unsigned CAP = rmt_pkg::CAPACITY_DEF;
	localparam int unsigned SW  = rmt_pkg::SAMPLE_WIDTH_DEF;
	localparam int unsigned CW  = $clog2(CAP + 1);

	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};

	// middle pair is averaged by this, truncating toward zero
	localparam int PAIR_DIVISOR = 2;

	// receiver hold-off length for the back-pressure test, in cycles
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned MAX_REPORTS = 50;

	typedef struct packed {
		logic signed [SW-1:0] median;
		logic        [CW-1:0] stored_count;
		logic                 dropped;
	} median_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [SW-1:0] sample;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [SW-1:0] median;
	logic        [CW-1:0] stored_count;
	logic                 dropped;

	// Predictor state: every held sample in ascending order, plus the count
	logic signed [SW-1:0] held_samples [CAP];
	int unsigned          held_count;

	median_result_t expected_results [$];
	int unsigned    failures;

	bit sender_calm;           // no gaps on the request side while set
	int unsigned hold_off_req = 0;   // bumped to ask the receiver for a long hold-off

	running_median_tracker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.median       (median),
		.stored_count (stored_count),
		.dropped      (dropped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Insert one sample into the sorted copy (equal values go after the
	// existing ones) and work out the result the block should report.
	function automatic median_result_t insert_and_predict(input logic signed [SW-1:0] value);
		median_result_t res;
		int unsigned    pos;
		longint signed  pair_sum;
		res.dropped = 1'b0;
		if (held_count >= CAP) begin
			// full store: sample discarded, median of the unchanged set
			res.dropped = 1'b1;
		end else begin
			pos = held_count;
			while (pos > 0 && held_samples[pos-1] > value) begin
				held_samples[pos] = held_samples[pos-1];
				pos--;
			end
			held_samples[pos] = value;
			held_count++;
		end
		if (held_count % 2 == 1) begin
			res.median = held_samples[held_count / 2];
		end else begin
			// wide sum so two extremes cannot wrap; SV division truncates toward zero
			pair_sum = longint'(held_samples[held_count/2 - 1])
				+ longint'(held_samples[held_count/2]);
			res.median = SW'(pair_sum / PAIR_DIVISOR);
		end
		res.stored_count = CW'(held_count);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mix of full-range values, values near both extremes and a narrow band
	// around zero that gives plenty of duplicates and odd pair sums.
	function automatic logic signed [SW-1:0] random_sample();
		logic signed [SW-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v = SAMPLE_MIN + v[1:0];
			1: v = SAMPLE_MAX - v[1:0];
			2, 3, 4: v = v[5:0] - 32;
			default: ;
		endcase
		return v;
	endfunction

	// Offer one request and hold it until accepted. Valid is only lowered
	// when a gap follows, so it never gets two updates in one step.
	task automatic send_sample(input logic signed [SW-1:0] value);
		int unsigned gap;
		gap = idle_gap(sender_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample   <= value;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(insert_and_predict(value));
	endtask

	// Extremes first: min pair overflows negatively, min/max pair has an
	// odd negative sum, later max pair overflows positively.
	task automatic test_extremes();
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample('0);
		send_sample(-1);
		send_sample(1);
		send_sample(-3);
		send_sample(-4);
		send_sample(SW'('h5555_5555));
		send_sample(SW'('haaaa_aaaa));
	endtask

	// Runs of equal values, on both sides of the current middle
	task automatic test_equal_samples();
		repeat (4) send_sample(7);
		repeat (3) send_sample(-7);
		repeat (3) send_sample(SAMPLE_MAX);
	endtask

	// Receiver stalls for a long stretch while requests keep coming, so the
	// output register and then the input side back up.
	task automatic test_backpressure();
		sender_calm = 1'b1;
		hold_off_req <= hold_off_req + 1;
		repeat (24) send_sample(random_sample());
		sender_calm = 1'b0;
	endtask

	// Random requests until the store is full, with calm bursts in between
	task automatic test_random_fill();
		int unsigned n;
		n = 0;
		while (held_count < CAP) begin
			if (n % 40 == 0)
				sender_calm = ($urandom_range(0, 2) == 0);
			send_sample(random_sample());
			n++;
		end
		sender_calm = 1'b0;
	endtask

	// Store full: every further request is discarded and flagged
	task automatic test_full_store();
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		for (int i = 0; i < 250; i++) begin
			if (i % 40 == 0)
				sender_calm = ($urandom_range(0, 2) == 0);
			send_sample(random_sample());
		end
		sender_calm = 1'b0;
	endtask

	// Result receiver: random stalls, calm stretches, and one long hold-off
	// when the back-pressure test asks for it.
	initial begin : receiver
		int unsigned stall_left;
		int unsigned calm_left;
		int unsigned hold_off_ack;
		stall_left   = 0;
		calm_left    = 0;
		hold_off_ack = 0;
		out_ready    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req != hold_off_ack) begin
				hold_off_ack = hold_off_req;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 19) == 0)
					calm_left = $urandom_range(20, 80);
				else
					stall_left = idle_gap(1'b0);
			end
		end
	end

	// Result checker: oldest expectation against each accepted result
	always @(posedge clk) begin : check_results
		median_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: unexpected result median=%0d count=%0d dropped=%0b",
						$time, median, stored_count, dropped);
			end else begin
				exp_res = expected_results.pop_front();
				if (median !== exp_res.median) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("%0t: median expected %0d actual %0d",
							$time, exp_res.median, median);
				end
				if (stored_count !== exp_res.stored_count) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("%0t: stored_count expected %0d actual %0d",
							$time, exp_res.stored_count, stored_count);
				end
				if (dropped !== exp_res.dropped) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("%0t: dropped expected %0b actual %0b",
							$time, exp_res.dropped, dropped);
				end
			end
		end
	end

	// Main sequence
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample      = '0;
		held_count  = 0;
		failures    = 0;
		sender_calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_equal_samples();
		test_backpressure();
		test_random_fill();
		test_full_store();

		in_valid <= 1'b0;
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
rtl/rmt_pkg.sv
rtl/rmt_cell.sv
rtl/rmt_chain.sv
rtl/running_median_tracker.sv
rtl/rmt_checker.sv
tb/running_median_tracker_tb.sv
